/* sv/sle_pkg.sv */
// shared codes, characters and echo sequence tables for the serial line editor
// no dependencies
package sle_pkg;

    localparam logic [1:0] ACT_RX   = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_TAKE = 2'd2;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_K      = 8'h4B;

    typedef logic [1:0] t_seq;
    typedef logic [2:0] t_step;

    localparam t_seq SEQ_ONE   = 2'd0;
    localparam t_seq SEQ_ENTER = 2'd1;
    localparam t_seq SEQ_ERASE = 2'd2;

    // cr esc [ 1 B  /  esc [ 1 D esc [ K
    function automatic logic [7:0] echo_byte(input t_seq seq, input t_step step);
        logic [7:0] b;
        b = CH_NUL;
        case (seq)
            SEQ_ENTER: begin
                case (step)
                    3'd0:    b = CH_CR;
                    3'd1:    b = CH_ESC;
                    3'd2:    b = CH_LBRACK;
                    3'd3:    b = CH_ONE;
                    3'd4:    b = CH_B;
                    default: b = CH_NUL;
                endcase
            end
            SEQ_ERASE: begin
                case (step)
                    3'd0:    b = CH_ESC;
                    3'd1:    b = CH_LBRACK;
                    3'd2:    b = CH_ONE;
                    3'd3:    b = CH_D;
                    3'd4:    b = CH_ESC;
                    3'd5:    b = CH_LBRACK;
                    3'd6:    b = CH_K;
                    default: b = CH_NUL;
                endcase
            end
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

    function automatic t_step seq_last_step(input t_seq seq);
        t_step s;
        case (seq)
            SEQ_ENTER: s = 3'd4;
            SEQ_ERASE: s = 3'd6;
            default:   s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

/* sv/sle_store.sv */
// line store memory: one write port, one registered read port, per-entry valid bits
// unwritten entries read as zero; no package dependencies
module sle_store #(
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // write in the same cycle as the read wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
                r_rd_hit  <= 1'b1;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
                r_rd_hit  <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 8'h00;

endmodule

/* sv/serial_line_editor_echo_top.sv */
// serial line editor top level: input register, edit logic, echo sequencer
// depends on sle_pkg and sle_store
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per received byte,
//   line read or line take. Output channel (o_out_valid / i_out_stall) carries
//   echo bytes and read replies; o_last marks the final beat of one input.
//   A plain byte gives one echo beat, carriage return five, delete seven,
//   read and take one; a dropped byte, delete at line start and action 3 none.
//   The input beat is first loaded into the input register; the result
//   register is loaded from it when the edit logic commits that input.
//   Throughput: one output beat per cycle while i_out_stall is low; an input
//   that makes N beats holds the result register until its last beat leaves,
//   so unstalled single-beat inputs flow one per cycle and the edit logic
//   takes the next input as the last beat of the current one leaves. The
//   result register is the only pacing point.
//   Reset (synchronous, active low) empties both registers, zeroes the write
//   position and ready flag, and marks every line store entry as zero.
//   When the receiver stalls the result beat holds; the input register keeps
//   one more input, then o_in_stall rises.
module serial_line_editor_echo_top
    import sle_pkg::*;
#(
    parameter int LINE_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_rx_byte,
    input  logic [5:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_reply_kind,
    output logic [7:0] o_data_byte,
    output logic       o_line_ready,
    output logic       o_last
);

    localparam int DEPTH = LINE_MAX + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LMAX_A = AW'(LINE_MAX);
    localparam logic [5:0]    LMAX_I = 6'(LINE_MAX);

    // input register
    logic       r_in_valid;
    logic [1:0] r_action;
    logic [7:0] r_rx_byte;
    logic       r_rd_oor;

    // editor state
    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;
    logic          r_ready;
    logic          n_ready;

    // result register and echo sequencer
    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_data;
    logic       r_out_ready;
    t_seq       r_seq;
    t_step      r_step;

    logic          in_accept;
    logic          out_free;
    logic          commit;
    logic          rd_oor;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          wr_en_c;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          emit;
    logic          e_kind;
    logic [7:0]    e_data;
    logic          e_ready;
    t_seq          e_seq;
    t_step         nxt_step;

    assign o_last     = (r_step == seq_last_step(r_seq));
    assign out_free   = !r_out_valid || (!i_out_stall && o_last);
    assign commit     = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign rd_oor  = (i_read_index > LMAX_I);
    assign rd_addr = rd_oor ? '0 : i_read_index[AW-1:0];

    sle_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (commit && wr_en_c),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action  <= i_action;
            r_rx_byte <= i_rx_byte;
            r_rd_oor  <= rd_oor;
        end
    end

    // edit decision for the item in the input register
    always_comb begin
        n_pos   = r_pos;
        n_ready = r_ready;
        wr_en_c = 1'b0;
        wr_addr = r_pos;
        wr_data = CH_NUL;
        emit    = 1'b0;
        e_kind  = KIND_ECHO;
        e_data  = r_rx_byte;
        e_ready = r_ready;
        e_seq   = SEQ_ONE;
        case (r_action)
            ACT_RX: begin
                if (r_rx_byte == CH_CR) begin
                    // terminate line at current position
                    wr_en_c = 1'b1;
                    n_ready = 1'b1;
                    n_pos   = '0;
                    emit    = 1'b1;
                    e_seq   = SEQ_ENTER;
                    e_data  = CH_CR;
                    e_ready = 1'b1;
                end else if (r_rx_byte == CH_DEL) begin
                    if (r_pos != '0) begin
                        n_pos   = r_pos - 1'b1;
                        wr_en_c = 1'b1;
                        wr_addr = r_pos - 1'b1;
                        emit    = 1'b1;
                        e_seq   = SEQ_ERASE;
                        e_data  = CH_ESC;
                    end
                end else if (r_pos < LMAX_A) begin
                    wr_en_c = 1'b1;
                    wr_data = r_rx_byte;
                    n_pos   = r_pos + 1'b1;
                    emit    = 1'b1;
                end
            end
            ACT_READ: begin
                emit   = 1'b1;
                e_kind = KIND_READ;
                e_data = r_rd_oor ? CH_NUL : rd_data;
            end
            ACT_TAKE: begin
                emit    = 1'b1;
                e_kind  = KIND_READ;
                e_data  = CH_NUL;
                n_ready = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ready <= 1'b0;
        end else if (commit) begin
            r_pos   <= n_pos;
            r_ready <= n_ready;
        end
    end

    assign nxt_step = r_step + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit && emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall && o_last) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && emit) begin
            r_kind      <= e_kind;
            r_data      <= e_data;
            r_out_ready <= e_ready;
            r_seq       <= e_seq;
            r_step      <= '0;
        end else if (r_out_valid && !i_out_stall && !o_last) begin
            // next byte of an escape sequence
            r_step <= nxt_step;
            r_data <= echo_byte(r_seq, nxt_step);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reply_kind = r_kind;
    assign o_data_byte  = r_data;
    assign o_line_ready = r_out_ready;

endmodule

/* sim/testbench.sv */
// self-checking testbench for serial_line_editor_echo_top: typed lines, deletes, reads, takes
// keeps its own line-editor state to predict every echo and reply beat; needs sle_pkg and the rtl
module testbench;
    import sle_pkg::*;

    localparam int LINE_MAX = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 260;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0] action;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
        logic       hold;       // wait until every expected beat has arrived
    } t_edit_item;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       ready;
        logic       last;
    } t_reply;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_action = ACT_RX;
    logic [7:0] i_rx_byte = 8'h00;
    logic [5:0] i_read_index = 6'd0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_reply_kind;
    logic [7:0] o_data_byte;
    logic       o_line_ready;
    logic       o_last;

    serial_line_editor_echo_top #(.LINE_MAX(LINE_MAX)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reply_kind (o_reply_kind),
        .o_data_byte  (o_data_byte),
        .o_line_ready (o_line_ready),
        .o_last       (o_last)
    );

    // predicted editor state
    logic [7:0] line_buf [0:LINE_MAX];
    logic [5:0] wr_pos;
    logic       ready_flag;

    t_edit_item item_q[$];
    t_reply     reply_q[$];
    t_edit_item cur_item;

    int errors = 0;
    int cycles = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int lines_entered = 0;
    int bytes_dropped = 0;
    int erases = 0;
    int reads_out_of_range = 0;
    int gap_left = 0;
    int stall_left = 0;
    logic took;
    logic calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("serial_line_editor_echo_top: mismatch");
            $finish;
        end
    end

    task automatic push_reply(input logic kind, input logic [7:0] data, input logic ready,
                              input logic last);
        t_reply r;
        r.kind = kind;
        r.data = data;
        r.ready = ready;
        r.last = last;
        reply_q.push_back(r);
    endtask

    // line editor behavior for one accepted beat
    task automatic edit_line(input t_edit_item it);
        logic [7:0] enter_seq [0:4];
        logic [7:0] erase_seq [0:6];
        logic       was_ready;
        enter_seq = '{CH_CR, CH_ESC, CH_LBRACK, CH_ONE, CH_B};
        erase_seq = '{CH_ESC, CH_LBRACK, CH_ONE, CH_D, CH_ESC, CH_LBRACK, CH_K};
        case (it.action)
            ACT_RX: begin
                if (it.rx_byte == CH_CR) begin
                    line_buf[wr_pos] = CH_NUL;
                    ready_flag = 1'b1;
                    wr_pos = '0;
                    lines_entered++;
                    for (int k = 0; k < 5; k++)
                        push_reply(KIND_ECHO, enter_seq[k], ready_flag, k == 4);
                end else if (it.rx_byte == CH_DEL) begin
                    if (wr_pos != 0) begin
                        wr_pos = wr_pos - 1'b1;
                        line_buf[wr_pos] = CH_NUL;
                        erases++;
                        for (int k = 0; k < 7; k++)
                            push_reply(KIND_ECHO, erase_seq[k], ready_flag, k == 6);
                    end
                end else if (wr_pos >= LINE_MAX) begin
                    bytes_dropped++;
                end else begin
                    line_buf[wr_pos] = it.rx_byte;
                    wr_pos = wr_pos + 1'b1;
                    push_reply(KIND_ECHO, it.rx_byte, ready_flag, 1'b1);
                end
            end
            ACT_READ: begin
                if (it.read_index > LINE_MAX) begin
                    reads_out_of_range++;
                    push_reply(KIND_READ, CH_NUL, ready_flag, 1'b1);
                end else begin
                    push_reply(KIND_READ, line_buf[it.read_index], ready_flag, 1'b1);
                end
            end
            ACT_TAKE: begin
                was_ready = ready_flag;
                ready_flag = 1'b0;
                push_reply(KIND_READ, CH_NUL, was_ready, 1'b1);
            end
            default: ;
        endcase
    endtask

    function automatic int pick_idle(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // long quiet stretches with no idling on either side
    assign calm = ((beats_sent / 40) % 4) == 3;

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                edit_line(cur_item);
                beats_sent++;
                gap_left = pick_idle(calm);
            end
            if (!i_in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (item_q.size() > 0 && !(item_q[0].hold && reply_q.size() != 0)) begin
                    cur_item = item_q.pop_front();
                    i_action <= cur_item.action;
                    i_rx_byte <= cur_item.rx_byte;
                    i_read_index <= cur_item.read_index;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    $error("result beat with nothing expected: kind %0b data %0h",
                           o_reply_kind, o_data_byte);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("reply_kind", want.kind, o_reply_kind);
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("line_ready", want.ready, o_line_ready);
                    check_field("last", want.last, o_last);
                    beats_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_idle(calm);
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    int n_items = 0;

    task automatic add_item(input logic [1:0] act, input logic [7:0] b, input logic [5:0] idx,
                            input logic hold);
        t_edit_item it;
        it.action = act;
        it.rx_byte = b;
        it.read_index = idx;
        it.hold = hold;
        item_q.push_back(it);
        if (act != ACT_NONE)
            n_items++;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_CR || b == CH_DEL)
            b = b ^ 8'h40;
        return b;
    endfunction

    function automatic logic [5:0] any_index();
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(LINE_MAX + 1, 63));
        return 6'($urandom_range(0, LINE_MAX));
    endfunction

    task automatic add_line();
        int len;
        len = ($urandom_range(0, 99) < 15) ? $urandom_range(LINE_MAX - 4, LINE_MAX + 8)
                                          : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 12)
                add_item(ACT_RX, CH_DEL, 6'($urandom_range(0, 63)), 1'b0);
            else
                add_item(ACT_RX, plain_char(), 6'($urandom_range(0, 63)), 1'b0);
        end
        if ($urandom_range(0, 9) != 0)
            add_item(ACT_RX, CH_CR, 6'($urandom_range(0, 63)), 1'b0);
        repeat ($urandom_range(0, 3))
            add_item(ACT_READ, 8'($urandom_range(0, 255)), any_index(), 1'b0);
        if ($urandom_range(0, 4) != 0)
            add_item(ACT_TAKE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), 1'b0);
    endtask

    initial begin
        int r;
        for (int k = 0; k <= LINE_MAX; k++)
            line_buf[k] = CH_NUL;
        wr_pos = '0;
        ready_flag = 1'b0;

        // directed part
        add_item(ACT_TAKE, 8'h00, 6'd0, 1'b0);          // take with the flag already clear
        add_item(ACT_READ, 8'h00, 6'd0, 1'b0);
        add_item(ACT_READ, 8'hFF, 6'd63, 1'b0);         // read past the line store
        add_item(ACT_READ, 8'h00, 6'd33, 1'b0);
        add_item(ACT_RX, CH_DEL, 6'd0, 1'b0);           // delete at line start
        add_item(ACT_RX, CH_NUL, 6'd0, 1'b0);           // zero byte is a plain character
        add_item(ACT_RX, 8'hFF, 6'd0, 1'b0);
        add_item(ACT_RX, 8'h80, 6'd0, 1'b0);
        add_item(ACT_RX, 8'h41, 6'd0, 1'b0);
        add_item(ACT_RX, CH_DEL, 6'd0, 1'b0);
        add_item(ACT_READ, 8'h00, 6'd1, 1'b0);
        add_item(ACT_READ, 8'h00, 6'd3, 1'b0);
        add_item(ACT_NONE, CH_CR, 6'd5, 1'b0);          // unused action is ignored
        add_item(ACT_RX, CH_CR, 6'd0, 1'b0);
        add_item(ACT_RX, 8'h55, 6'd0, 1'b0);
        add_item(ACT_READ, 8'h00, 6'd0, 1'b0);
        add_item(ACT_READ, 8'h00, 6'd3, 1'b0);
        add_item(ACT_READ, 8'h00, 6'd32, 1'b0);
        add_item(ACT_TAKE, 8'hFF, 6'd63, 1'b0);
        add_item(ACT_TAKE, 8'h00, 6'd0, 1'b0);
        add_item(ACT_RX, CH_DEL, 6'd0, 1'b1);

        // random part, mostly well-formed lines
        while (n_items < RANDOM_ITEMS + 21) begin
            if (n_items > 150 && n_items < 160)
                add_item(ACT_READ, 8'h00, any_index(), 1'b1);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_line();
            end else if (r < 85) begin
                if ($urandom_range(0, 1) != 0)
                    add_item(ACT_READ, 8'($urandom_range(0, 255)), any_index(), 1'b0);
                else
                    add_item(ACT_TAKE, 8'($urandom_range(0, 255)),
                             6'($urandom_range(0, 63)), 1'b0);
            end else if (r < 95) begin
                repeat ($urandom_range(1, 4))
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             6'($urandom_range(0, 63)), 1'b0);
            end else begin
                // broken input: runs of deletes or bare carriage returns
                repeat ($urandom_range(1, 5))
                    add_item(ACT_RX, ($urandom_range(0, 1) != 0) ? CH_DEL : CH_CR,
                             6'($urandom_range(0, 63)), 1'b0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (item_q.size() != 0 || i_in_valid || reply_q.size() != 0);
        repeat (16) @(posedge i_clk);

        if (reply_q.size() != 0) begin
            $error("%0d expected result beats never arrived", reply_q.size());
            errors++;
        end
        $display("%0d input beats and %0d result beats checked under random idling and stalls",
                 beats_sent, beats_checked);
        $display("%0d lines entered, %0d erases, %0d bytes dropped on full line, %0d far reads",
                 lines_entered, erases, bytes_dropped, reads_out_of_range);
        if (errors == 0)
            $display("serial_line_editor_echo_top: match");
        else
            $display("serial_line_editor_echo_top: mismatch");
        $finish;
    end

endmodule
